// File: src/bms_pkg.sv
package bms_pkg;

    localparam int unsigned NoteTickW   = 10;
    localparam int unsigned RepeatW     = 16;
    localparam int unsigned PulseW      = 16;
    localparam int unsigned ReloadW     = 12;
    localparam int unsigned ElapsedW    = 8;
    localparam int unsigned NoteIdxW    = 3;
    localparam int unsigned TuneW       = 2;
    localparam int unsigned CfgIndexW   = 2;
    localparam int unsigned CfgDataW    = 16;
    localparam int unsigned InDataW     = 8;
    localparam int unsigned OutDataW    = 32;

    localparam logic [NoteTickW-1:0] NoteTickReset   = 10'd125;
    localparam logic [RepeatW-1:0]   RepeatReset     = 16'd5000;
    localparam logic [PulseW-1:0]    PulseReset      = 16'd100;

    typedef enum logic [1:0] {
        CMD_TICK = 2'd0,
        CMD_PLAY = 2'd1,
        CMD_STOP = 2'd2
    } cmd_t;

    typedef enum logic [CfgIndexW-1:0] {
        CFG_NOTE_TICK   = 2'd0,
        CFG_REPEAT      = 2'd1,
        CFG_PULSE_WIDTH = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [NoteTickW-1:0] note_tick_ms;
        logic [RepeatW-1:0]   repeat_period_ms;
        logic [PulseW-1:0]    pulse_width_us;
    } bms_cfg_t;

    typedef struct packed {
        logic                 tick_gen_enabled;
        logic [NoteTickW-1:0] tick_countdown;
        logic                 tick_pending;
        logic                 repeat_gen_enabled;
        logic [RepeatW-1:0]   repeat_countdown;
        logic                 repeat_pending;
        logic                 play_active;
        logic                 repeat_mode;
        logic [TuneW-1:0]     current_tune;
        logic [NoteIdxW-1:0]  note_index;
        logic [ElapsedW-1:0]  note_elapsed;
        logic [ReloadW-1:0]   current_reload;
        logic [PulseW-1:0]    compare_latch;
    } bms_state_t;

    // Tunes: 0 power heat, 1 heat, 2 warm, 3 stop.
    function automatic logic [ReloadW-1:0] tune_reload(input logic [TuneW-1:0] t,
                                                       input logic [NoteIdxW-1:0] i);
        logic [ReloadW-1:0] r;
        r = '0;
        unique case (t)
            2'd0: unique case (i)
                3'd0:    r = 12'd2400;
                3'd1:    r = 12'd1200;
                default: r = '0;
            endcase
            2'd1: unique case (i)
                3'd0:    r = 12'd1912;
                3'd1:    r = 12'd1703;
                3'd2:    r = 12'd1517;
                default: r = '0;
            endcase
            2'd2: unique case (i)
                3'd0:    r = 12'd1517;
                3'd1:    r = 12'd1703;
                3'd2:    r = 12'd1912;
                default: r = '0;
            endcase
            default: unique case (i)
                3'd0:    r = 12'd1517;
                3'd1:    r = 12'd1703;
                3'd2:    r = 12'd1912;
                3'd3:    r = 12'd1703;
                3'd4:    r = 12'd1912;
                default: r = '0;
            endcase
        endcase
        return r;
    endfunction

    function automatic logic [ElapsedW-1:0] tune_dur(input logic [TuneW-1:0] t,
                                                     input logic [NoteIdxW-1:0] i);
        logic [ElapsedW-1:0] d;
        d = '0;
        unique case (t)
            2'd0: unique case (i)
                3'd0:    d = 8'd1;
                3'd1:    d = 8'd2;
                default: d = '0;
            endcase
            2'd1: unique case (i)
                3'd0:    d = 8'd2;
                3'd1:    d = 8'd1;
                3'd2:    d = 8'd2;
                default: d = '0;
            endcase
            2'd2: unique case (i)
                3'd0:    d = 8'd2;
                3'd1:    d = 8'd1;
                3'd2:    d = 8'd6;
                default: d = '0;
            endcase
            default: unique case (i)
                3'd0:    d = 8'd2;
                3'd1:    d = 8'd1;
                3'd2:    d = 8'd2;
                3'd3:    d = 8'd1;
                3'd4:    d = 8'd6;
                default: d = '0;
            endcase
        endcase
        return d;
    endfunction

    function automatic logic [NoteIdxW:0] tune_len(input logic [TuneW-1:0] t);
        logic [NoteIdxW:0] n;
        unique case (t)
            2'd0:    n = 4'd2;
            2'd1:    n = 4'd3;
            2'd2:    n = 4'd3;
            default: n = 4'd5;
        endcase
        return n;
    endfunction

    function automatic logic tune_repeats(input logic [TuneW-1:0] t);
        return (t == 2'd0) || (t == 2'd1);
    endfunction

endpackage

// File: src/bms_core.sv
module bms_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  logic [1:0]                          cmd,
    input  logic [bms_pkg::TuneW-1:0]           tune,
    input  bms_pkg::bms_cfg_t                   cfg,
    output bms_pkg::bms_state_t                 state_next
);

    bms_pkg::bms_state_t state_reg;

    function automatic bms_pkg::bms_state_t start_play(input bms_pkg::bms_state_t s,
                                                      input bms_pkg::bms_cfg_t c);
        bms_pkg::bms_state_t r;
        r = s;
        r.play_active      = 1'b1;
        r.note_index       = '0;
        r.tick_gen_enabled = 1'b1;
        r.tick_countdown   = c.note_tick_ms;
        r.compare_latch    = c.pulse_width_us;
        r.current_reload   = bms_pkg::tune_reload(s.current_tune, '0);
        return r;
    endfunction

    function automatic bms_pkg::bms_state_t end_play(input bms_pkg::bms_state_t s,
                                                    input bms_pkg::bms_cfg_t c,
                                                    input logic forced);
        bms_pkg::bms_state_t r;
        r = s;
        r.play_active      = 1'b0;
        r.note_index       = '0;
        r.note_elapsed     = '0;
        r.tick_pending     = 1'b0;
        r.tick_gen_enabled = 1'b0;
        if (!forced && s.repeat_mode)
        begin
            r.repeat_gen_enabled = 1'b1;
            r.repeat_countdown   = c.repeat_period_ms;
        end
        return r;
    endfunction

    always_comb
    begin
        bms_pkg::bms_state_t    n;
        logic [bms_pkg::ElapsedW-1:0] dur;
        logic [bms_pkg::NoteIdxW:0]   idx_inc;
        n       = state_reg;
        dur     = '0;
        idx_inc = '0;
        if (en)
        begin
            unique case (cmd)
                bms_pkg::CMD_TICK:
                begin
                    if (n.tick_gen_enabled)
                    begin
                        if (n.tick_countdown <= 10'd1)
                        begin
                            n.tick_pending   = 1'b1;
                            n.tick_countdown = cfg.note_tick_ms;
                        end
                        else
                        begin
                            n.tick_countdown = n.tick_countdown - 10'd1;
                        end
                    end
                    if (n.repeat_gen_enabled)
                    begin
                        if (n.repeat_countdown <= 16'd1)
                        begin
                            n.repeat_pending   = 1'b1;
                            n.repeat_countdown = cfg.repeat_period_ms;
                        end
                        else
                        begin
                            n.repeat_countdown = n.repeat_countdown - 16'd1;
                        end
                    end
                    // A restart wins over a note tick; the tick waits for the next word.
                    if (n.repeat_pending)
                    begin
                        n.repeat_pending = 1'b0;
                        n = start_play(n, cfg);
                    end
                    else if (n.tick_pending)
                    begin
                        n.tick_pending = 1'b0;
                        if (n.play_active)
                        begin
                            n.note_elapsed = n.note_elapsed + 8'd1;
                            dur = bms_pkg::tune_dur(n.current_tune, n.note_index);
                            if (!(dur > n.note_elapsed))
                            begin
                                idx_inc = {1'b0, n.note_index} + 4'd1;
                                if (idx_inc >= bms_pkg::tune_len(n.current_tune))
                                begin
                                    n = end_play(n, cfg, 1'b0);
                                end
                                else
                                begin
                                    n.note_index     = idx_inc[bms_pkg::NoteIdxW-1:0];
                                    n.note_elapsed   = '0;
                                    n.current_reload = bms_pkg::tune_reload(
                                        n.current_tune, idx_inc[bms_pkg::NoteIdxW-1:0]);
                                end
                            end
                        end
                    end
                end
                bms_pkg::CMD_PLAY:
                begin
                    n.current_tune = tune;
                    n.repeat_mode  = bms_pkg::tune_repeats(tune);
                    n = start_play(n, cfg);
                end
                bms_pkg::CMD_STOP:
                begin
                    n = end_play(n, cfg, 1'b1);
                end
                default:
                begin
                end
            endcase
        end
        state_next = n;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: src/buzzer_melody_sequencer.sv
// Buzzer melody sequencer. Each input word is a command (a one millisecond tick,
// play a tune, or force stop) and produces exactly one output word carrying the
// buzzer enable, the reload count of the current note, the latched pulse width
// and the playing flag as they stand after that command. A word is registered on
// input, processed combinationally by the note and repeat timers and registered
// again on output, so one word per clock is sustained while the result stream is not
// stalled; the input register can take a new word while a result still waits to be
// taken. Configuration writes take effect at once and should be made while idle.
module buzzer_melody_sequencer (
    input  logic                               clk,
    input  logic                               rst_n,
    // Configuration
    input  logic                               cfg_wr_en,
    input  logic [bms_pkg::CfgIndexW-1:0]      cfg_index,
    input  logic [bms_pkg::CfgDataW-1:0]       cfg_data,
    // Command stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [bms_pkg::InDataW-1:0]        s_tdata,   // cmd[1:0], tune[3:2]
    // Result stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [bms_pkg::OutDataW-1:0]       m_tdata    // buzzer_on[0], reload_count[12:1],
                                                          // pulse_width[28:13], playing[29]
);

    bms_pkg::bms_cfg_t   cfg_reg;
    bms_pkg::bms_state_t state_next;

    logic                          in_valid_reg;
    logic [1:0]                    cmd_reg;
    logic [bms_pkg::TuneW-1:0]     tune_reg;
    logic                          out_valid_reg;
    logic [bms_pkg::OutDataW-1:0]  out_data_reg;
    logic [bms_pkg::OutDataW-1:0]  out_data_next;
    logic                          advance;
    logic                          in_accept;

    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign in_accept = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.note_tick_ms     <= bms_pkg::NoteTickReset;
            cfg_reg.repeat_period_ms <= bms_pkg::RepeatReset;
            cfg_reg.pulse_width_us   <= bms_pkg::PulseReset;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                bms_pkg::CFG_NOTE_TICK:
                    cfg_reg.note_tick_ms <= cfg_data[bms_pkg::NoteTickW-1:0];
                bms_pkg::CFG_REPEAT:
                    cfg_reg.repeat_period_ms <= cfg_data;
                bms_pkg::CFG_PULSE_WIDTH:
                    cfg_reg.pulse_width_us <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_accept || (in_valid_reg && !advance);
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            cmd_reg  <= s_tdata[1:0];
            tune_reg <= s_tdata[3:2];
        end
    end

    bms_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (advance),
        .cmd        (cmd_reg),
        .tune       (tune_reg),
        .cfg        (cfg_reg),
        .state_next (state_next)
    );

    assign out_data_next = {2'b00,
                            state_next.play_active,
                            state_next.compare_latch,
                            state_next.current_reload,
                            state_next.play_active};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= advance || (out_valid_reg && !m_tready);
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// File: src/bms_checker.sv
module bms_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               m_tvalid,
    input logic                               m_tready,
    input logic [bms_pkg::OutDataW-1:0]       m_tdata
);

    logic [bms_pkg::ReloadW-1:0] reload;
    assign reload = m_tdata[12:1];

    // A stalled result word holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // The buzzer is enabled exactly while a tune plays.
    a_buzzer_play: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[0] == m_tdata[29])
        else $error("buzzer_on and playing disagree");

    // While playing, a real note pitch is loaded.
    a_play_reload: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[29] |-> reload != 12'd0)
        else $error("playing with no note loaded");

    // The reload count is always one of the tune pitches or the reset value.
    a_reload_set: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (reload == 12'd0) || (reload == 12'd2400) || (reload == 12'd1200) ||
                     (reload == 12'd1912) || (reload == 12'd1703) || (reload == 12'd1517))
        else $error("reload count outside the tune tables");

endmodule

bind buzzer_melody_sequencer bms_checker u_bms_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
